// ----- sv/vpe_pkg.sv -----
// Shared types, constants and command codes for the voiced plosive envelope.
package vpe_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int FRAMES_BITS    = 16;
  localparam int RAMP_BITS      = 9;
  localparam int Q16_BITS       = 16;
  localparam int DECAY_BITS     = 17;
  localparam int SMOOTH_BITS    = 17;
  localparam int LP_BITS        = 24;
  localparam int MUL_A_BITS     = 33;
  localparam int MUL_B_BITS     = 18;
  localparam int PROD_BITS      = MUL_A_BITS + MUL_B_BITS;
  localparam int DIV_STEPS      = 8;
  localparam int DIV_CNT_BITS   = 3;

  localparam logic [SMOOTH_BITS-1:0] ONE_Q16  = 17'h10000;
  localparam logic [MUL_B_BITS-1:0]  SMOOTH_K = 18'h30000;
  localparam logic signed [PROD_BITS-1:0] ROUND16 = PROD_BITS'(64'd1 << 15);
  localparam logic signed [PROD_BITS-1:0] ROUND32 = PROD_BITS'(64'd1 << 31);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CLOSURE_FRAMES = 3'd0,
    REG_BURST_FRAMES   = 3'd1,
    REG_BURST_RAMP     = 3'd2,
    REG_CLOSURE_RAMP   = 3'd3,
    REG_LOWPASS_COEFF  = 3'd4,
    REG_VOICING_GAIN   = 3'd5,
    REG_DECAY_STEP     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [FRAMES_BITS-1:0] closure_frames;
    logic [FRAMES_BITS-1:0] burst_frames;
    logic [RAMP_BITS-1:0]   burst_ramp;
    logic [RAMP_BITS-1:0]   closure_ramp;
    logic [Q16_BITS-1:0]    lowpass_coeff;
    logic [Q16_BITS-1:0]    voicing_gain;
    logic [Q16_BITS-1:0]    decay_step;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    closure_frames: 16'd480,
    burst_frames:   16'd960,
    burst_ramp:     9'd48,
    closure_ramp:   9'd48,
    lowpass_coeff:  16'd61374,
    voicing_gain:   16'd16384,
    decay_step:     16'd65106
  };

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_LP_MX,
    OP_LP_MC,
    OP_LP_SUM,
    OP_RAMP,
    OP_DIV,
    OP_SQ,
    OP_SMUL,
    OP_SRND,
    OP_MUL_GAIN,
    OP_MUL_NOISE,
    OP_MUL_SA,
    OP_MUL_SB,
    OP_MUL_DECAY,
    OP_ROUND,
    OP_DECAY_MUL,
    OP_DECAY_SET,
    OP_FINAL
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ramp_b;
  } dp_cmd_t;

  typedef struct packed {
    logic past;
    logic closure;
    logic done_a;
    logic done_b;
  } dp_status_t;

endpackage

// ----- sv/vpe_stream_if.sv -----
// Valid/ready channel interfaces for the input and result transfers.
interface vpe_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] excitation_sample;
  logic signed [SAMPLE_BITS-1:0] noise_sample;

  modport source (output valid, excitation_sample, noise_sample, input ready);
  modport sink (input valid, excitation_sample, noise_sample, output ready);
endinterface

interface vpe_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          gesture_end;
  logic                          overrun;

  modport source (output valid, out_sample, gesture_end, overrun, input ready);
  modport sink (input valid, out_sample, gesture_end, overrun, output ready);
endinterface

// ----- sv/vpe_cfg.sv -----
// Configuration register bank with write-only port.
module vpe_cfg
  import vpe_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOSURE_FRAMES: cfg.closure_frames <= cfg_data;
        REG_BURST_FRAMES:   cfg.burst_frames   <= cfg_data;
        REG_BURST_RAMP:     cfg.burst_ramp     <= cfg_data[RAMP_BITS-1:0];
        REG_CLOSURE_RAMP:   cfg.closure_ramp   <= cfg_data[RAMP_BITS-1:0];
        REG_LOWPASS_COEFF:  cfg.lowpass_coeff  <= cfg_data;
        REG_VOICING_GAIN:   cfg.voicing_gain   <= cfg_data;
        REG_DECAY_STEP:     cfg.decay_step     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/vpe_ctrl.sv -----
// Sequencing state machine: steps the datapath through one frame.
module vpe_ctrl
  import vpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_LP0, S_LP1, S_LP2, S_RAMP, S_DIV, S_SQ, S_SMUL, S_SRND,
    S_M1, S_R1, S_M2, S_R2, S_M3, S_R3, S_DMUL, S_DSET, S_FINAL
  } state_t;

  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

  state_t                  state;
  logic                    ramp_b;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic                    ramp_done;
  logic                    out_free;

  assign in_ready  = (state == S_IDLE);
  assign ramp_done = ramp_b ? status.done_b : status.done_a;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ramp_b    <= 1'b0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINAL) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_LP0;
        S_LP0:  state <= status.past ? S_FINAL : S_LP1;
        S_LP1:  state <= S_LP2;
        S_LP2: begin
          ramp_b <= 1'b0;
          state  <= S_RAMP;
        end
        S_RAMP: begin
          div_cnt <= '0;
          if (!ramp_done) begin
            state <= S_DIV;
          end else if (ramp_b) begin
            state <= S_M1;
          end else begin
            ramp_b <= 1'b1;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) state <= S_SQ;
        end
        S_SQ:   state <= S_SMUL;
        S_SMUL: state <= S_SRND;
        S_SRND: begin
          if (ramp_b) begin
            state <= S_M1;
          end else begin
            ramp_b <= 1'b1;
            state  <= S_RAMP;
          end
        end
        S_M1: state <= S_R1;
        S_R1: state <= S_M2;
        S_M2: state <= S_R2;
        S_R2: state <= S_M3;
        S_M3: state <= S_R3;
        S_R3: state <= (!status.closure && status.done_a) ? S_DMUL : S_FINAL;
        S_DMUL: state <= S_DSET;
        S_DSET: state <= S_FINAL;
        S_FINAL: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.op     = OP_NOP;
    cmd.ramp_b = ramp_b;
    unique case (state)
      S_IDLE:  if (in_valid) cmd.op = OP_CAPTURE;
      S_LP0:   if (!status.past) cmd.op = OP_LP_MX;
      S_LP1:   cmd.op = OP_LP_MC;
      S_LP2:   cmd.op = OP_LP_SUM;
      S_RAMP:  cmd.op = OP_RAMP;
      S_DIV:   cmd.op = OP_DIV;
      S_SQ:    cmd.op = OP_SQ;
      S_SMUL:  cmd.op = OP_SMUL;
      S_SRND:  cmd.op = OP_SRND;
      S_M1:    cmd.op = status.closure ? OP_MUL_GAIN : OP_MUL_NOISE;
      S_M2:    cmd.op = status.closure ? OP_MUL_SA : OP_MUL_SB;
      S_M3:    cmd.op = status.closure ? OP_MUL_SB : OP_MUL_DECAY;
      S_R1, S_R2, S_R3: cmd.op = OP_ROUND;
      S_DMUL:  cmd.op = OP_DECAY_MUL;
      S_DSET:  cmd.op = OP_DECAY_SET;
      S_FINAL: if (out_free) cmd.op = OP_FINAL;
      default: cmd.op = OP_NOP;
    endcase
  end

endmodule

// ----- sv/vpe_datapath.sv -----
// Datapath: frame state, shared multiplier, ramp divider and output register.
module vpe_datapath
  import vpe_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 17
)
(
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  dp_cmd_t                       cmd,
  input  logic signed [SAMPLE_BITS-1:0] excitation_sample,
  input  logic signed [SAMPLE_BITS-1:0] noise_sample,
  output dp_status_t                    status,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          gesture_end,
  output logic                          overrun
);

  localparam int FRAC = LP_BITS - SAMPLE_BITS;
  localparam int CW   = (COUNT_BITS > FRAMES_BITS + 1) ? COUNT_BITS : FRAMES_BITS + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic signed [MUL_A_BITS-1:0] HALF_F = MUL_A_BITS'((64'd1 << FRAC) >> 1);
  localparam logic signed [MUL_A_BITS-1:0] SAT_HI =
    MUL_A_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [MUL_A_BITS-1:0] SAT_LO = ~SAT_HI;

  // frame state
  logic [COUNT_BITS-1:0]          frame_index;
  logic signed [LP_BITS-1:0]      lowpass_level;
  logic [DECAY_BITS-1:0]          decay_level;

  // per-frame working registers
  logic signed [SAMPLE_BITS-1:0]  x_s;
  logic signed [SAMPLE_BITS-1:0]  noise_s;
  logic                           past, closure, last, done_a, done_b;
  logic [FRAMES_BITS-1:0]         n_a, n_b;
  logic [RAMP_BITS-1:0]           ramp_len;
  logic [RAMP_BITS-1:0]           rem;
  logic [Q16_BITS-1:0]            quot;
  logic [SMOOTH_BITS-1:0]         s_a, s_b;
  logic signed [PROD_BITS-1:0]    acc, prod;
  logic signed [MUL_A_BITS-1:0]   res;

  // frame classification
  logic [CW-1:0]                  frame_w, cf_w, total_w, local_w, nb_cl_w, nb_bu_w;
  logic                           c_past, c_closure, c_last;
  logic [FRAMES_BITS-1:0]         c_na, c_nb;
  logic [RAMP_BITS-1:0]           c_ramp_raw, c_ramp;

  always_comb begin
    frame_w    = CW'(frame_index);
    cf_w       = CW'(cfg.closure_frames);
    total_w    = CW'(cfg.closure_frames) + CW'(cfg.burst_frames);
    local_w    = frame_w - cf_w;
    nb_cl_w    = cf_w - CW'(1) - frame_w;
    nb_bu_w    = total_w - CW'(1) - frame_w;
    c_past     = frame_w >= total_w;
    c_closure  = frame_w < cf_w;
    c_last     = frame_w == (total_w - CW'(1));
    c_na       = c_closure ? frame_w[FRAMES_BITS-1:0] : local_w[FRAMES_BITS-1:0];
    c_nb       = c_closure ? nb_cl_w[FRAMES_BITS-1:0] : nb_bu_w[FRAMES_BITS-1:0];
    c_ramp_raw = c_closure ? cfg.closure_ramp : cfg.burst_ramp;
    c_ramp     = (c_ramp_raw == '0) ? RAMP_BITS'(1) : c_ramp_raw;
  end

  // ramp position divider, two quotient bits a cycle
  logic [RAMP_BITS:0]   r1, d1, r2, d2;
  logic                 ge1, ge2;
  logic [FRAMES_BITS-1:0] n_sel;

  always_comb begin
    n_sel = cmd.ramp_b ? n_b : n_a;
    r1    = {rem, 1'b0};
    ge1   = r1 >= {1'b0, ramp_len};
    d1    = ge1 ? r1 - {1'b0, ramp_len} : r1;
    r2    = {d1[RAMP_BITS-1:0], 1'b0};
    ge2   = r2 >= {1'b0, ramp_len};
    d2    = ge2 ? r2 - {1'b0, ramp_len} : r2;
  end

  // shared multiplier, signed A by unsigned B
  logic signed [MUL_A_BITS-1:0]   mul_a;
  logic [MUL_B_BITS-1:0]          mul_b;
  logic signed [PROD_BITS-1:0]    mul_full;
  logic signed [LP_BITS-1:0]      x_wide;

  assign x_wide = LP_BITS'(x_s) <<< FRAC;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_LP_MX: begin
        mul_a = MUL_A_BITS'(x_wide);
        mul_b = MUL_B_BITS'(ONE_Q16 - SMOOTH_BITS'(cfg.lowpass_coeff));
      end
      OP_LP_MC: begin
        mul_a = MUL_A_BITS'(lowpass_level);
        mul_b = MUL_B_BITS'(cfg.lowpass_coeff);
      end
      OP_SQ: begin
        mul_a = MUL_A_BITS'(quot);
        mul_b = MUL_B_BITS'(quot);
      end
      OP_SMUL: begin
        mul_a = prod[MUL_A_BITS-1:0];
        mul_b = SMOOTH_K - {1'b0, quot, 1'b0};
      end
      OP_MUL_GAIN: begin
        mul_a = MUL_A_BITS'(lowpass_level);
        mul_b = MUL_B_BITS'(cfg.voicing_gain);
      end
      OP_MUL_NOISE: begin
        mul_a = MUL_A_BITS'(noise_s);
        mul_b = MUL_B_BITS'(s_a);
      end
      OP_MUL_SA: begin
        mul_a = res;
        mul_b = MUL_B_BITS'(s_a);
      end
      OP_MUL_SB: begin
        mul_a = res;
        mul_b = MUL_B_BITS'(s_b);
      end
      OP_MUL_DECAY: begin
        mul_a = res;
        mul_b = MUL_B_BITS'(decay_level);
      end
      OP_DECAY_MUL: begin
        mul_a = MUL_A_BITS'(decay_level);
        mul_b = MUL_B_BITS'(cfg.decay_step);
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  // round-half-up shifts
  logic signed [PROD_BITS-1:0]    rnd16, lp_sum, srnd;
  logic signed [MUL_A_BITS-1:0]   fin_v;
  logic signed [MUL_A_BITS-1:0]   sat_v;

  always_comb begin
    rnd16  = prod + ROUND16;
    lp_sum = acc + prod + ROUND16;
    srnd   = prod + ROUND32;
    fin_v  = closure ? ((res + HALF_F) >>> FRAC) : res;
    if (fin_v > SAT_HI) begin
      sat_v = SAT_HI;
    end else if (fin_v < SAT_LO) begin
      sat_v = SAT_LO;
    end else begin
      sat_v = fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index   <= '0;
      lowpass_level <= '0;
      decay_level   <= DECAY_BITS'(ONE_Q16);
    end else begin
      unique case (cmd.op)
        OP_NOP: ;
        OP_CAPTURE: begin
          x_s      <= excitation_sample;
          noise_s  <= noise_sample;
          past     <= c_past;
          closure  <= c_closure;
          last     <= c_last;
          n_a      <= c_na;
          n_b      <= c_nb;
          ramp_len <= c_ramp;
          done_a   <= c_na >= FRAMES_BITS'(c_ramp);
          done_b   <= c_nb >= FRAMES_BITS'(c_ramp);
        end
        OP_LP_MX: prod <= mul_full[PROD_BITS-1:0];
        OP_LP_MC: begin
          acc  <= prod;
          prod <= mul_full[PROD_BITS-1:0];
        end
        OP_LP_SUM: lowpass_level <= lp_sum[Q16_BITS +: LP_BITS];
        OP_RAMP: begin
          rem  <= n_sel[RAMP_BITS-1:0];
          quot <= '0;
          if (cmd.ramp_b ? done_b : done_a) begin
            if (cmd.ramp_b) s_b <= ONE_Q16;
            else            s_a <= ONE_Q16;
          end
        end
        OP_DIV: begin
          rem  <= d2[RAMP_BITS-1:0];
          quot <= {quot[Q16_BITS-3:0], ge1, ge2};
        end
        OP_SQ, OP_SMUL, OP_MUL_GAIN, OP_MUL_NOISE, OP_MUL_SA, OP_MUL_SB,
        OP_MUL_DECAY, OP_DECAY_MUL: prod <= mul_full[PROD_BITS-1:0];
        OP_SRND: begin
          if (cmd.ramp_b) s_b <= srnd[32 +: SMOOTH_BITS];
          else            s_a <= srnd[32 +: SMOOTH_BITS];
        end
        OP_ROUND:     res <= rnd16[Q16_BITS +: MUL_A_BITS];
        OP_DECAY_SET: decay_level <= rnd16[Q16_BITS +: DECAY_BITS];
        OP_FINAL: begin
          if (past) begin
            out_sample  <= '0;
            gesture_end <= 1'b0;
            overrun     <= 1'b1;
          end else begin
            out_sample  <= sat_v[SAMPLE_BITS-1:0];
            gesture_end <= last;
            overrun     <= 1'b0;
            if (frame_index != COUNT_MAX) frame_index <= frame_index + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign status.past    = past;
  assign status.closure = closure;
  assign status.done_a  = done_a;
  assign status.done_b  = done_b;

endmodule

// ----- sv/voiced_plosive_envelope.sv -----
// Voiced plosive envelope: top level joining config bank, sequencer and datapath.
//
// One excitation/noise pair enters on in_ch per audio frame and one shaped sample
// leaves on out_ch, flagged with gesture_end on the last frame and overrun past it.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only while the
// block is idle; the user must see to this, as the block does not enforce it.
// The block works on one frame at a time; in_ch.ready is high only when idle.
// Each frame in the gesture updates the lowpass, takes a 16-bit ramp position from
// a two-bit-per-cycle divider and then smoothstep on the shared 33x18 multiplier for
// each ramp in progress, forms the envelope products and, in the burst after its
// attack, updates the decay. A frame past the end of the gesture skips all of this.
// The result sits in an output register; a new frame is accepted while it waits,
// and that frame's result is held back until the previous transfer completes.
// Reset (synchronous, active high) restores register defaults, clears the frame
// counter and lowpass, and sets the decay to one.
module voiced_plosive_envelope
  import vpe_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 17
)
(
  input  logic                      clk,
  input  logic                      rst,
  vpe_in_if.sink                    in_ch,
  vpe_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t                          cfg;
  dp_cmd_t                       cmd;
  dp_status_t                    status;
  logic                          in_ready;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          gesture_end;
  logic                          overrun;

  vpe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  vpe_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd               (cmd),
    .excitation_sample (in_ch.excitation_sample),
    .noise_sample      (in_ch.noise_sample),
    .status            (status),
    .out_sample        (out_sample),
    .gesture_end       (gesture_end),
    .overrun           (overrun)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.out_sample  = out_sample;
  assign out_ch.gesture_end = gesture_end;
  assign out_ch.overrun     = overrun;

endmodule
